// ===== design/qts_pkg.sv =====
`timescale 1ns / 1ps

package qts_pkg;

   localparam logic [1:0] MODE_PLAY  = 2'd0;
   localparam logic [1:0] MODE_TIME  = 2'd1;
   localparam logic [1:0] MODE_FLUSH = 2'd2;

   localparam logic [2:0] CLK_OFF    = 3'd0;
   localparam logic [2:0] CLK_DIV8   = 3'd2;
   localparam logic [2:0] CLK_DIV64  = 3'd3;
   localparam logic [2:0] CLK_DIV256 = 3'd4;

   localparam logic [7:0] COMPARE_STOP = 8'hFF;
   localparam logic [3:0] NOTE_LIMIT   = 4'd12;
   localparam logic [3:0] OCTAVE_LIMIT = 4'd8;

   localparam logic [7:0] TONE_ROWS [3][12] = '{
      '{8'd142, 8'd134, 8'd127, 8'd120, 8'd113, 8'd106,
        8'd100, 8'd95,  8'd89,  8'd84,  8'd79,  8'd75},
      '{8'd71,  8'd67,  8'd63,  8'd59,  8'd56,  8'd53,
        8'd50,  8'd47,  8'd44,  8'd42,  8'd39,  8'd37},
      '{8'd35,  8'd33,  8'd31,  8'd29,  8'd27,  8'd26,
        8'd24,  8'd23,  8'd22,  8'd20,  8'd19,  8'd18}
   };

   localparam logic [1:0] OCTAVE_ROW [8] = '{
      2'd0, 2'd1, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2
   };

   localparam logic [2:0] OCTAVE_CLK [8] = '{
      CLK_DIV256, CLK_DIV256, CLK_DIV64, CLK_DIV64,
      CLK_DIV64, CLK_DIV8, CLK_DIV8, CLK_DIV8
   };

   typedef struct packed {
      logic [3:0]  note;
      logic [2:0]  octave;
      logic [31:0] hold;
   } entry_type;

   typedef struct packed {
      logic [7:0] compare;
      logic [2:0] clock;
   } tone_type;

   typedef struct packed {
      logic capture;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic out_free;
   } status_type;

   function automatic tone_type tone_lookup(input logic [3:0] note, input logic [2:0] octave);
      tone_type   t;
      logic [3:0] nt;
      logic [7:0] b;
      nt = (note < NOTE_LIMIT) ? note : 4'd0;
      b = TONE_ROWS[OCTAVE_ROW[octave]][nt];
      t.compare = b - 8'd1;
      t.clock = OCTAVE_CLK[octave];
      return t;
   endfunction

endpackage

// ===== design/qts_ctrl.sv =====
`timescale 1ns / 1ps

module qts_ctrl
   import qts_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_READ = 3'b010,
      ST_EXEC = 3'b100
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd.capture = 1'b0;
      cmd.commit = 1'b0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (status.out_free) begin
               cmd.commit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== design/qts_datapath.sv =====
`timescale 1ns / 1ps

module qts_datapath
   import qts_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16
)
(
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output status_type  status,
   input  logic [1:0]  req_mode,
   input  logic [3:0]  req_note_index,
   input  logic [3:0]  req_octave_index,
   input  logic [31:0] req_hold_ms,
   input  logic [31:0] req_now_ms,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_playing,
   output logic [7:0]  rsp_compare_value,
   output logic [2:0]  rsp_clock_select,
   output logic [4:0]  rsp_queue_count,
   output logic        rsp_accepted
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

   entry_type mem [QUEUE_DEPTH];
   entry_type rd_ff;

   logic [1:0]  mode_ff;
   logic [3:0]  note_ff;
   logic [3:0]  octave_ff;
   logic [31:0] hold_ff;
   logic [31:0] now_ff;

   logic [PTR_W-1:0] head_ff, head_in;
   logic [PTR_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             tone_on_ff, tone_on_in;
   logic [31:0]      end_ff, end_in;
   logic [7:0]       compare_ff, compare_in;
   logic [2:0]       clock_ff, clock_in;
   logic             accepted_in;
   logic             push;

   logic             rsp_valid_ff;
   logic             rsp_playing_ff;
   logic [7:0]       rsp_compare_ff;
   logic [2:0]       rsp_clock_ff;
   logic [4:0]       rsp_count_ff;
   logic             rsp_accepted_ff;

   tone_type         tone;
   logic             expired;

   assign tone = tone_lookup(rd_ff.note, rd_ff.octave);
   assign expired = now_ff > end_ff;

   always_comb begin
      head_in = head_ff;
      tail_in = tail_ff;
      count_in = count_ff;
      tone_on_in = tone_on_ff;
      end_in = end_ff;
      compare_in = compare_ff;
      clock_in = clock_ff;
      accepted_in = 1'b0;
      push = 1'b0;
      unique case (mode_ff)
         MODE_PLAY: begin
            if (note_ff < NOTE_LIMIT && octave_ff < OCTAVE_LIMIT && count_ff < CNT_FULL) begin
               push = 1'b1;
               tail_in = (tail_ff == PTR_LAST) ? '0 : tail_ff + 1'b1;
               count_in = count_ff + 1'b1;
               accepted_in = 1'b1;
            end
         end
         MODE_TIME: begin
            if ((!tone_on_ff || expired) && count_ff != '0) begin
               head_in = (head_ff == PTR_LAST) ? '0 : head_ff + 1'b1;
               count_in = count_ff - 1'b1;
               if (rd_ff.hold != 32'd0) begin
                  compare_in = tone.compare;
                  clock_in = tone.clock;
                  tone_on_in = 1'b1;
                  end_in = now_ff + rd_ff.hold;
               end
            end else if (tone_on_ff && expired) begin
               tone_on_in = 1'b0;
               compare_in = COMPARE_STOP;
               clock_in = CLK_OFF;
            end
         end
         MODE_FLUSH: begin
            tone_on_in = 1'b0;
            compare_in = COMPARE_STOP;
            clock_in = CLK_OFF;
            head_in = '0;
            tail_in = '0;
            count_in = '0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.commit && push) begin
         mem[tail_ff] <= '{note: note_ff, octave: octave_ff[2:0], hold: hold_ff};
      end
      rd_ff <= mem[head_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff <= req_mode;
         note_ff <= req_note_index;
         octave_ff <= req_octave_index;
         hold_ff <= req_hold_ms;
         now_ff <= req_now_ms;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         count_ff <= '0;
         tone_on_ff <= 1'b0;
         end_ff <= '0;
         compare_ff <= COMPARE_STOP;
         clock_ff <= CLK_OFF;
      end else if (cmd.commit) begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         count_ff <= count_in;
         tone_on_ff <= tone_on_in;
         end_ff <= end_in;
         compare_ff <= compare_in;
         clock_ff <= clock_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_playing_ff <= tone_on_in;
         rsp_compare_ff <= compare_in;
         rsp_clock_ff <= clock_in;
         rsp_count_ff <= 5'(count_in);
         rsp_accepted_ff <= accepted_in;
      end
   end

   assign status.out_free = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_playing = rsp_playing_ff;
   assign rsp_compare_value = rsp_compare_ff;
   assign rsp_clock_select = rsp_clock_ff;
   assign rsp_queue_count = rsp_count_ff;
   assign rsp_accepted = rsp_accepted_ff;

endmodule

// ===== design/queued_tone_sequencer.sv =====
`timescale 1ns / 1ps

// Tone player with a queue of QUEUE_DEPTH pending notes. Each request (mode 0 play,
// 1 time update, 2 flush) passes three steps: capture, queue head read from the
// note memory's registered port, then commit of the new state into the response
// register. req_stall is low only while the controller is idle, so one request is
// in flight at a time; a new one is taken while the previous response still waits,
// and its commit holds until that response has been taken. No reset sweep: the
// note memory's read-out is used only at entries that were queued.

module queued_tone_sequencer
   import qts_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_mode,
   input  logic [3:0]  req_note_index,
   input  logic [3:0]  req_octave_index,
   input  logic [31:0] req_hold_ms,
   input  logic [31:0] req_now_ms,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_playing,
   output logic [7:0]  rsp_compare_value,
   output logic [2:0]  rsp_clock_select,
   output logic [4:0]  rsp_queue_count,
   output logic        rsp_accepted
);

   cmd_type    cmd;
   status_type status;

   qts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   qts_datapath #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_mode          (req_mode),
      .req_note_index    (req_note_index),
      .req_octave_index  (req_octave_index),
      .req_hold_ms       (req_hold_ms),
      .req_now_ms        (req_now_ms),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_playing       (rsp_playing),
      .rsp_compare_value (rsp_compare_value),
      .rsp_clock_select  (rsp_clock_select),
      .rsp_queue_count   (rsp_queue_count),
      .rsp_accepted      (rsp_accepted)
   );

`ifndef SYNTHESIS
   a_commit_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_valid)
      else $error("commit did not present a response");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while another is in flight");

   a_playing_clocked: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_playing |-> rsp_clock_select != CLK_OFF)
      else $error("tone reported without a prescaler");
`endif

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
   import qts_pkg::*;

   localparam int QUEUE_DEPTH      = 16;
   localparam int RANDOM_ITEMS     = 450;
   localparam int LONG_HOLD_AT     = 200;
   localparam int LONG_HOLD_CYCLES = 150;
   localparam int DRAIN_AT         = 320;
   localparam int CALM_TAIL        = 60;
   localparam int WATCHDOG_LIMIT   = 3000;
   localparam int SETTLE_CYCLES    = 8;

   localparam logic [1:0] MODE_SPARE = 2'd3;

   localparam logic [7:0] PITCH_BYTE [3][12] = '{
      '{8'd142, 8'd134, 8'd127, 8'd120, 8'd113, 8'd106,
        8'd100, 8'd95,  8'd89,  8'd84,  8'd79,  8'd75},
      '{8'd71,  8'd67,  8'd63,  8'd59,  8'd56,  8'd53,
        8'd50,  8'd47,  8'd44,  8'd42,  8'd39,  8'd37},
      '{8'd35,  8'd33,  8'd31,  8'd29,  8'd27,  8'd26,
        8'd24,  8'd23,  8'd22,  8'd20,  8'd19,  8'd18}
   };
   localparam int OCT_ROW_SEL [8] = '{0, 1, 0, 1, 2, 0, 1, 2};
   localparam logic [2:0] OCT_PRESCALE [8] = '{
      CLK_DIV256, CLK_DIV256, CLK_DIV64, CLK_DIV64,
      CLK_DIV64, CLK_DIV8, CLK_DIV8, CLK_DIV8
   };

   typedef struct packed {
      logic [3:0]  note;
      logic [2:0]  octave;
      logic [31:0] hold;
   } queued_note_type;

   typedef struct packed {
      logic       playing;
      logic [7:0] compare;
      logic [2:0] clk_sel;
      logic [4:0] count;
      logic       accepted;
   } tone_status_type;

   typedef struct packed {
      logic [1:0]      mode;
      logic [3:0]      note;
      logic [3:0]      octave;
      logic [31:0]     hold;
      logic [31:0]     now;
      logic [4:0]      reps;
      logic [7:0]      now_step;
      logic            typed;
      tone_status_type want;
   } script_row_type;

   localparam tone_status_type IDLE_ST = '{1'b0, COMPARE_STOP, CLK_OFF, 5'd0, 1'b0};
   localparam tone_status_type FULL_ST = '{1'b0, COMPARE_STOP, CLK_OFF, 5'd16, 1'b0};

   localparam script_row_type DIRECTED [25] = '{
      '{MODE_TIME,  4'd0,  4'd0,  32'd0,  32'd0,  5'd1, 8'd0, 1'b1, IDLE_ST},
      '{MODE_FLUSH, 4'd0,  4'd0,  32'd0,  32'd0,  5'd1, 8'd0, 1'b1, IDLE_ST},
      '{MODE_SPARE, 4'd15, 4'd15, 32'hFFFFFFFF, 32'hFFFFFFFF, 5'd1, 8'd0, 1'b1, IDLE_ST},
      '{MODE_PLAY,  4'd12, 4'd0,  32'd7,  32'd0,  5'd1, 8'd0, 1'b1, IDLE_ST},
      '{MODE_PLAY,  4'd15, 4'd15, 32'd7,  32'd0,  5'd1, 8'd0, 1'b1, IDLE_ST},
      '{MODE_PLAY,  4'd0,  4'd8,  32'd7,  32'd0,  5'd1, 8'd0, 1'b1, IDLE_ST},
      '{MODE_PLAY,  4'd0,  4'd0,  32'd0,  32'd0,  5'd1, 8'd0, 1'b1,
        '{1'b0, COMPARE_STOP, CLK_OFF, 5'd1, 1'b1}},
      '{MODE_TIME,  4'd0,  4'd0,  32'd0,  32'd5,  5'd1, 8'd0, 1'b1, IDLE_ST},
      '{MODE_PLAY,  4'd0,  4'd0,  32'd10, 32'd0,  5'd1, 8'd0, 1'b1,
        '{1'b0, COMPARE_STOP, CLK_OFF, 5'd1, 1'b1}},
      '{MODE_PLAY,  4'd11, 4'd7,  32'hFFFFFFFF, 32'd0, 5'd1, 8'd0, 1'b1,
        '{1'b0, COMPARE_STOP, CLK_OFF, 5'd2, 1'b1}},
      '{MODE_TIME,  4'd0,  4'd0,  32'd0,  32'd100, 5'd1, 8'd0, 1'b1,
        '{1'b1, 8'd141, CLK_DIV256, 5'd1, 1'b0}},
      '{MODE_TIME,  4'd0,  4'd0,  32'd0,  32'd110, 5'd1, 8'd0, 1'b1,
        '{1'b1, 8'd141, CLK_DIV256, 5'd1, 1'b0}},
      '{MODE_TIME,  4'd0,  4'd0,  32'd0,  32'd111, 5'd1, 8'd0, 1'b1,
        '{1'b1, 8'd17, CLK_DIV8, 5'd0, 1'b0}},
      '{MODE_TIME,  4'd0,  4'd0,  32'd0,  32'hFFFFFFFF, 5'd1, 8'd0, 1'b1, IDLE_ST},
      '{MODE_PLAY,  4'd3,  4'd1,  32'd5,  32'd0,  5'd1, 8'd0, 1'b0, '0},
      '{MODE_PLAY,  4'd6,  4'd2,  32'd5,  32'd0,  5'd1, 8'd0, 1'b0, '0},
      '{MODE_PLAY,  4'd9,  4'd3,  32'd5,  32'd0,  5'd1, 8'd0, 1'b0, '0},
      '{MODE_PLAY,  4'd1,  4'd4,  32'd5,  32'd0,  5'd1, 8'd0, 1'b0, '0},
      '{MODE_PLAY,  4'd4,  4'd5,  32'd5,  32'd0,  5'd1, 8'd0, 1'b0, '0},
      '{MODE_PLAY,  4'd7,  4'd6,  32'd5,  32'd0,  5'd1, 8'd0, 1'b0, '0},
      '{MODE_TIME,  4'd0,  4'd0,  32'd0,  32'd1000, 5'd7, 8'd10, 1'b0, '0},
      '{MODE_PLAY,  4'd5,  4'd3,  32'd1,  32'd0,  5'd16, 8'd0, 1'b0, '0},
      '{MODE_PLAY,  4'd2,  4'd2,  32'd9,  32'd0,  5'd1, 8'd0, 1'b1, FULL_ST},
      '{MODE_SPARE, 4'd0,  4'd0,  32'd0,  32'd0,  5'd1, 8'd0, 1'b1, FULL_ST},
      '{MODE_FLUSH, 4'd0,  4'd0,  32'd0,  32'd0,  5'd1, 8'd0, 1'b1, IDLE_ST}
   };

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_mode = MODE_PLAY;
   logic [3:0]  req_note_index = '0;
   logic [3:0]  req_octave_index = '0;
   logic [31:0] req_hold_ms = '0;
   logic [31:0] req_now_ms = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_playing;
   logic [7:0]  rsp_compare_value;
   logic [2:0]  rsp_clock_select;
   logic [4:0]  rsp_queue_count;
   logic        rsp_accepted;

   queued_tone_sequencer #(.QUEUE_DEPTH(QUEUE_DEPTH)) dut (.*);

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // player state as seen by the predictor
   queued_note_type note_store [QUEUE_DEPTH];
   logic [3:0]  rd_ptr = '0;
   logic [3:0]  wr_ptr = '0;
   logic [4:0]  held_count = '0;
   logic        sounding = 1'b0;
   logic [31:0] stop_at = '0;
   logic [7:0]  cmp_now = COMPARE_STOP;
   logic [2:0]  clk_now = CLK_OFF;

   tone_status_type status_due [$];
   int  mismatches = 0;
   int  requests_taken = 0;
   int  send_quiet_left = 0;
   bit  wind_down = 1'b0;
   int  stall_left = 0;
   int  stall_free_run = 0;
   bit  long_hold_done = 1'b0;
   int  idle_cycles = 0;

   function automatic void silence();
      sounding = 1'b0;
      cmp_now = COMPARE_STOP;
      clk_now = CLK_OFF;
   endfunction

   function automatic void launch_next(input logic [31:0] t);
      queued_note_type e;
      e = note_store[rd_ptr];
      rd_ptr++;
      held_count--;
      if (e.hold != 0) begin
         cmp_now = PITCH_BYTE[OCT_ROW_SEL[e.octave]][e.note] - 8'd1;
         clk_now = OCT_PRESCALE[e.octave];
         sounding = 1'b1;
         stop_at = t + e.hold;
      end
   endfunction

   function automatic tone_status_type play_step(input logic [1:0] m, input logic [3:0] n,
                                                 input logic [3:0] o, input logic [31:0] h,
                                                 input logic [31:0] t);
      tone_status_type s;
      s.accepted = 1'b0;
      case (m)
         MODE_PLAY: begin
            if (n < NOTE_LIMIT && o < OCTAVE_LIMIT && held_count < QUEUE_DEPTH) begin
               note_store[wr_ptr] = '{n, o[2:0], h};
               wr_ptr++;
               held_count++;
               s.accepted = 1'b1;
            end
         end
         MODE_TIME: begin
            if (sounding) begin
               if (t > stop_at) begin
                  if (held_count != 0) launch_next(t);
                  else silence();
               end
            end else if (held_count != 0) begin
               launch_next(t);
            end
         end
         MODE_FLUSH: begin
            silence();
            rd_ptr = '0;
            wr_ptr = '0;
            held_count = '0;
         end
         default: ;
      endcase
      s.playing = sounding;
      s.compare = cmp_now;
      s.clk_sel = clk_now;
      s.count = held_count;
      return s;
   endfunction

   task automatic offer_request(input logic [1:0] m, input logic [3:0] n, input logic [3:0] o,
                                input logic [31:0] h, input logic [31:0] t, input bit drain,
                                input bit typed, input tone_status_type typed_want);
      int gap;
      tone_status_type predicted;
      gap = 0;
      if (!wind_down) begin
         if (send_quiet_left == 0) begin
            gap = $urandom_range(1, 9);
            send_quiet_left = $urandom_range(0, 20);
         end else begin
            send_quiet_left--;
         end
      end
      if (drain) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while (status_due.size() != 0) @(posedge clock);
      end else if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= m;
      req_note_index <= n;
      req_octave_index <= o;
      req_hold_ms <= h;
      req_now_ms <= t;
      do @(posedge clock); while (req_stall);
      predicted = play_step(m, n, o, h, t);
      status_due.push_back(typed ? typed_want : predicted);
      requests_taken++;
   endtask

   task automatic compare_field(input string label, input int unsigned want,
                                input int unsigned got);
      if (want != got) begin
         $display("%0t ns: %s expected %0d, got %0d", $time, label, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      tone_status_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (status_due.size() == 0) begin
            $display("%0t ns: response with none outstanding, expected none, got count %0d",
                     $time, rsp_queue_count);
            mismatches++;
         end else begin
            want = status_due.pop_front();
            compare_field("playing", want.playing, rsp_playing);
            compare_field("compare_value", want.compare, rsp_compare_value);
            compare_field("clock_select", want.clk_sel, rsp_clock_select);
            compare_field("queue_count", want.count, rsp_queue_count);
            compare_field("accepted", want.accepted, rsp_accepted);
         end
      end
   end

   // response back-pressure: random bursts, one long hold-off, none at the tail
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else if (!long_hold_done && requests_taken >= LONG_HOLD_AT) begin
         long_hold_done = 1'b1;
         rsp_stall <= 1'b1;
         stall_left = LONG_HOLD_CYCLES - 1;
      end else if (wind_down || stall_free_run > 0) begin
         rsp_stall <= 1'b0;
         if (stall_free_run > 0) stall_free_run--;
      end else begin
         rsp_stall <= 1'b1;
         stall_left = $urandom_range(0, 8);
         stall_free_run = $urandom_range(0, 24);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      script_row_type row;
      logic [1:0]  m;
      logic [3:0]  n;
      logic [3:0]  o;
      logic [31:0] h;
      logic [31:0] t;
      logic [31:0] clock_ms;
      int          pick;
      int          sel;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED[i]) begin
         row = DIRECTED[i];
         for (int r = 0; r < row.reps; r++)
            offer_request(row.mode, row.note, row.octave, row.hold,
                          row.now + r * row.now_step, 1'b0, row.typed, row.want);
      end

      clock_ms = 32'd2000;
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         pick = $urandom_range(0, 99);
         m = MODE_SPARE;
         n = 4'($urandom_range(0, 15));
         o = 4'($urandom_range(0, 15));
         h = $urandom;
         t = $urandom;
         if (pick < 46) begin
            m = MODE_PLAY;
            if ($urandom_range(0, 9) != 0) begin
               n = 4'($urandom_range(0, 11));
               o = 4'($urandom_range(0, 7));
            end
            sel = $urandom_range(0, 19);
            if (sel < 2) h = '0;
            else if (sel < 17) h = $urandom_range(1, 40);
         end else if (pick < 92) begin
            m = MODE_TIME;
            if ($urandom_range(0, 19) == 0) clock_ms = $urandom;
            else clock_ms = clock_ms + $urandom_range(0, 25);
            t = clock_ms;
         end else if (pick < 96) begin
            m = MODE_FLUSH;
         end
         wind_down = (i >= RANDOM_ITEMS - CALM_TAIL);
         offer_request(m, n, o, h, t, i == DRAIN_AT, 1'b0, '0);
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (status_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0) $display("*** PASSED ***");
      else $display("*** FAILED ***");
      $finish;
   end

endmodule
